### hw/rtl/fts_pkg.sv
package fts_pkg;

    localparam int REQ_BITS = 2;
    localparam logic [REQ_BITS-1:0] REQ_UPDATE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_QUERY  = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_INIT   = 2'd2;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NOMINAL_PERIOD = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RESYNC_WINDOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_ADJUST     = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_FRAME_GAP  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PERIOD_GAIN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OFFSET_GAIN    = 3'd5;

    localparam int GAIN_BITS = 17;
    localparam int NOM_BITS  = 30;
    localparam int OUT_PER_BITS = 46;
    localparam int OUT_TIME_BITS = 48;
    localparam int IN_FRAME_BITS = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_ERR,
        ST_MUL,
        ST_MUL_WAIT,
        ST_PRED,
        ST_ADJ,
        ST_GAIN,
        ST_GAIN_WAIT,
        ST_APPLY,
        ST_OUT
    } fts_state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic mul_start;
        logic err_step;
        logic pred_step;
        logic adj_step;
        logic gain_start;
        logic apply_step;
        logic init_step;
        logic out_load;
    } fts_cmd_t;

    typedef struct packed {
        logic is_update;
        logic is_query;
        logic is_init;
        logic div_done;
        logic mul_done;
        logic gain_done;
        logic resync;
    } fts_status_t;

endpackage

### hw/rtl/fts_ctrl.sv
module fts_ctrl
    import fts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        out_slot_free,
    input  fts_status_t status,
    output fts_cmd_t    cmd
);

    fts_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_DECODE;
            ST_DECODE:
            begin
                if (status.is_update)     state_next = ST_DIV;
                else if (status.is_query) state_next = ST_MUL;
                else                      state_next = ST_OUT;
            end
            ST_DIV:       if (status.div_done) state_next = ST_MUL;
            ST_MUL:       state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (status.mul_done)
                    state_next = status.is_update ? ST_PRED : ST_OUT;
            end
            ST_PRED:      state_next = ST_ERR;
            ST_ERR:       state_next = status.resync ? ST_OUT : ST_ADJ;
            ST_ADJ:       state_next = ST_GAIN;
            ST_GAIN:      state_next = ST_GAIN_WAIT;
            ST_GAIN_WAIT: if (status.gain_done) state_next = ST_APPLY;
            ST_APPLY:     state_next = ST_OUT;
            ST_OUT:       if (out_slot_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DECODE:
            begin
                cmd.div_start = status.is_update;
                cmd.init_step = status.is_init;
            end
            ST_MUL:       cmd.mul_start = 1'b1;
            ST_PRED:      cmd.pred_step = 1'b1;
            ST_ERR:       cmd.err_step = 1'b1;
            ST_ADJ:       cmd.adj_step = 1'b1;
            ST_GAIN:      cmd.gain_start = 1'b1;
            ST_APPLY:     cmd.apply_step = 1'b1;
            ST_OUT:       cmd.out_load = out_slot_free;
            default:      cmd = '0;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_load_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_DECODE)
        else $error("load not followed by decode");
    a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE)
        else $error("result not followed by idle");

endmodule

### hw/rtl/fts_datapath.sv
module fts_datapath
    import fts_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int FRAME_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [REQ_BITS-1:0]      req_type,
    input  logic [IN_FRAME_BITS-1:0] frame_count,
    input  logic [OUT_TIME_BITS-1:0] clock_time,
    input  logic [NOM_BITS-1:0]      nominal_period,
    input  logic [31:0]              resync_window,
    input  logic [31:0]              max_adjust,
    input  logic [7:0]               max_frame_gap,
    input  logic [GAIN_BITS-1:0]     period_gain,
    input  logic [GAIN_BITS-1:0]     offset_gain,
    input  fts_cmd_t                 cmd,
    output fts_status_t              status,
    output logic                     r_accepted,
    output logic                     r_resynced,
    output logic [OUT_TIME_BITS-1:0] r_frame_time,
    output logic [OUT_PER_BITS-1:0]  r_period
);

    localparam int QW = TIME_BITS + FRAC_BITS;
    localparam int PW = NOM_BITS + FRAC_BITS;
    localparam int W  = 64;
    localparam logic [W-1:0] QMAX = W'({QW{1'b1}});
    localparam logic [W-1:0] PMAX = W'({PW{1'b1}});
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(65536);
    localparam int DCW = $clog2(W + 1);

    logic [REQ_BITS-1:0]   req_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [W-1:0]          tq_reg;
    logic [W-1:0]          pred_reg, pred_next;
    logic [FRAME_BITS-1:0] newest_reg, prev_reg;
    logic [W-1:0]          est_reg, nxt_reg;
    logic                  acc_reg, rs_reg;
    logic [W-1:0]          ftime_reg;

    logic                  fwd_reg;
    logic [FRAME_BITS-1:0] gap_reg;
    logic                  mneg_reg;
    logic [W-1:0]          dmag_reg;
    logic                  dneg_reg;
    logic                  eneg_reg;
    logic [W-1:0]          emag_reg;

    wire [FRAME_BITS-1:0] frame_in = frame_count[FRAME_BITS-1:0];
    wire [W-1:0] tq_in = {{(W-TIME_BITS){1'b0}}, clock_time[TIME_BITS-1:0]} << FRAC_BITS;
    wire [W-1:0] nom_q = W'({{(W-NOM_BITS){1'b0}}, nominal_period} << FRAC_BITS) & PMAX;

    // restoring divider for the measured period
    logic [W-1:0]   dv_quo_reg, dv_rem_reg, dv_num_reg;
    logic [DCW-1:0] dv_cnt_reg;
    logic           dv_busy_reg;
    logic [W:0]     dv_trial;
    assign dv_trial = {dv_rem_reg, dv_num_reg[W-1]} - {{(W+1-FRAME_BITS){1'b0}}, gap_reg};

    // shift-add multiplier: 64x32, one bit per cycle, saturating
    logic [W-1:0]   mu_a_reg;
    logic [FRAME_BITS-1:0] mu_b_reg;
    logic [W+FRAME_BITS-1:0] mu_acc_reg;
    logic           mu_busy_reg, mu_done_reg;
    logic [$clog2(FRAME_BITS+1)-1:0] mu_cnt_reg;
    wire [W-1:0] mu_res = (|mu_acc_reg[W+FRAME_BITS-1:W]) ? '1 : mu_acc_reg[W-1:0];

    // gain multiplier, magnitude times 17-bit gain, one gain bit per cycle
    logic [W-1:0]   g_mag_reg;
    logic [GAIN_BITS-1:0] g_g_reg;
    logic [W+GAIN_BITS-1:0] g_acc_reg;
    logic           g_busy_reg, g_done_reg, g_phase_reg;
    logic [$clog2(GAIN_BITS+1)-1:0] g_cnt_reg;
    wire [W-1:0] g_res = W'(g_acc_reg >> 16);

    logic [W:0] pred_sum;
    logic [W-1:0] emag_c;
    logic eneg_c;
    logic resync_c;
    logic [W-1:0] adj_c, lim;

    assign status.is_update = (req_reg == REQ_UPDATE) && fwd_reg;
    assign status.is_query  = (req_reg == REQ_QUERY);
    assign status.is_init   = (req_reg == REQ_INIT);
    assign status.div_done  = !dv_busy_reg && !cmd.div_start;
    assign status.mul_done  = mu_done_reg;
    // only the second gain product ends the wait
    assign status.gain_done = g_done_reg && g_phase_reg;
    assign status.resync    = resync_c;

    function automatic logic [W-1:0] apply_p(input logic [W-1:0] base, input logic neg,
                                            input logic [W-1:0] mag);
        logic [W:0] s;
        s = {1'b0, base} + {1'b0, mag};
        if (neg)
            apply_p = (mag >= base) ? '0 : base - mag;
        else
            apply_p = (s[W] || s[W-1:0] > PMAX) ? PMAX : s[W-1:0];
    endfunction

    assign pred_sum = {1'b0, pred_reg} + {1'b0, mu_res};
    assign pred_next = (pred_sum[W] || pred_sum[W-1:0] > QMAX) ? QMAX : pred_sum[W-1:0];
    assign eneg_c = tq_reg < pred_reg;
    assign emag_c = eneg_c ? pred_reg - tq_reg : tq_reg - pred_reg;
    assign resync_c = (emag_c > W'({{(W-32){1'b0}}, resync_window} << FRAC_BITS))
                      || (gap_reg > FRAME_BITS'(max_frame_gap));
    assign lim = W'({{(W-32){1'b0}}, max_adjust} << FRAC_BITS);
    assign adj_c = (g_res > lim) ? lim : g_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg    <= '0;
            newest_reg  <= '0;
            prev_reg    <= '0;
            est_reg     <= W'(64'd10000000 << FRAC_BITS) & PMAX;
            nxt_reg     <= W'(64'd10000000 << FRAC_BITS) & PMAX;
            dv_busy_reg <= 1'b0;
            mu_busy_reg <= 1'b0;
            mu_done_reg <= 1'b0;
            g_busy_reg  <= 1'b0;
            g_done_reg  <= 1'b0;
            g_phase_reg <= 1'b0;
            acc_reg     <= 1'b0;
            rs_reg      <= 1'b0;
        end
        else
        begin
            mu_done_reg <= 1'b0;
            g_done_reg  <= 1'b0;
            if (cmd.load)
            begin
                req_reg   <= req_type;
                frame_reg <= frame_in;
                tq_reg    <= tq_in;
                fwd_reg   <= frame_in > newest_reg;
                gap_reg   <= frame_in - newest_reg;
                acc_reg   <= 1'b0;
                rs_reg    <= 1'b0;
                ftime_reg <= '0;
            end
            if (cmd.init_step)
            begin
                pred_reg   <= '0;
                newest_reg <= '0;
                prev_reg   <= '0;
                est_reg    <= nom_q;
                nxt_reg    <= nom_q;
            end
            if (cmd.div_start)
            begin
                mneg_reg    <= tq_reg < pred_reg;
                dv_num_reg  <= (tq_reg < pred_reg) ? pred_reg - tq_reg : tq_reg - pred_reg;
                dv_rem_reg  <= '0;
                dv_quo_reg  <= '0;
                dv_cnt_reg  <= DCW'(W);
                dv_busy_reg <= 1'b1;
            end
            else if (dv_busy_reg)
            begin
                dv_num_reg <= dv_num_reg << 1;
                if (!dv_trial[W])
                begin
                    dv_rem_reg <= dv_trial[W-1:0];
                    dv_quo_reg <= {dv_quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg <= {dv_rem_reg[W-2:0], dv_num_reg[W-1]};
                    dv_quo_reg <= {dv_quo_reg[W-2:0], 1'b0};
                end
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == DCW'(1))
                    dv_busy_reg <= 1'b0;
            end
            if (cmd.mul_start)
            begin
                if (status.is_update)
                begin
                    mu_a_reg <= nxt_reg;
                    mu_b_reg <= gap_reg;
                    // period error from measured period, before the state moves
                    if (mneg_reg)
                    begin
                        dneg_reg <= 1'b1;
                        dmag_reg <= ((dv_quo_reg + est_reg) < dv_quo_reg) ? '1
                                    : dv_quo_reg + est_reg;
                    end
                    else if (dv_quo_reg >= est_reg)
                    begin
                        dneg_reg <= 1'b0;
                        dmag_reg <= dv_quo_reg - est_reg;
                    end
                    else
                    begin
                        dneg_reg <= 1'b1;
                        dmag_reg <= est_reg - dv_quo_reg;
                    end
                end
                else
                begin
                    mu_a_reg <= est_reg;
                    mu_b_reg <= (frame_reg <= newest_reg) ? newest_reg - frame_reg
                                                          : frame_reg - newest_reg;
                end
                mu_acc_reg  <= '0;
                mu_cnt_reg  <= '0;
                mu_busy_reg <= 1'b1;
            end
            else if (mu_busy_reg)
            begin
                if (mu_b_reg[0])
                    mu_acc_reg <= mu_acc_reg + ((W+FRAME_BITS)'(mu_a_reg) << mu_cnt_reg);
                mu_b_reg   <= mu_b_reg >> 1;
                mu_cnt_reg <= mu_cnt_reg + 1'b1;
                if (mu_cnt_reg == ($clog2(FRAME_BITS+1))'(FRAME_BITS - 1))
                begin
                    mu_busy_reg <= 1'b0;
                    mu_done_reg <= 1'b1;
                end
            end
            if (mu_done_reg && status.is_query)
            begin
                if (frame_reg <= newest_reg)
                    ftime_reg <= (mu_res >= pred_reg) ? '0 : (pred_reg - mu_res) >> FRAC_BITS;
                else
                    ftime_reg <= ((pred_sum[W] ? '1 : pred_sum[W-1:0]) >> FRAC_BITS);
            end
            if (cmd.pred_step)
            begin
                pred_reg   <= pred_next;
                prev_reg   <= newest_reg;
                newest_reg <= frame_reg;
                acc_reg    <= 1'b1;
            end
            if (cmd.err_step)
            begin
                eneg_reg <= eneg_c;
                emag_reg <= emag_c;
                if (resync_c)
                begin
                    nxt_reg  <= est_reg;
                    pred_reg <= tq_reg;
                    rs_reg   <= 1'b1;
                end
            end
            if (cmd.gain_start || (g_done_reg && !g_phase_reg))
            begin
                g_mag_reg  <= cmd.gain_start ? dmag_reg : emag_reg;
                g_g_reg    <= cmd.gain_start ? ((period_gain > GAIN_ONE) ? GAIN_ONE : period_gain)
                                             : ((offset_gain > GAIN_ONE) ? GAIN_ONE : offset_gain);
                g_phase_reg <= !cmd.gain_start;
                g_acc_reg  <= '0;
                g_cnt_reg  <= '0;
                g_busy_reg <= 1'b1;
                if (!cmd.gain_start)
                    est_reg <= apply_p(est_reg, dneg_reg, g_res);
            end
            else if (g_busy_reg)
            begin
                if (g_g_reg[0])
                    g_acc_reg <= g_acc_reg + ((W+GAIN_BITS)'(g_mag_reg) << g_cnt_reg);
                g_g_reg   <= g_g_reg >> 1;
                g_cnt_reg <= g_cnt_reg + 1'b1;
                if (g_cnt_reg == ($clog2(GAIN_BITS+1))'(GAIN_BITS - 1))
                begin
                    g_busy_reg <= 1'b0;
                    g_done_reg <= 1'b1;
                end
            end
            if (cmd.apply_step)
                nxt_reg <= apply_p(est_reg, eneg_reg, adj_c);
        end
    end

    assign r_accepted   = acc_reg;
    assign r_resynced   = rs_reg;
    assign r_frame_time = OUT_TIME_BITS'(ftime_reg > W'({TIME_BITS{1'b1}})
                                         ? W'({TIME_BITS{1'b1}}) : ftime_reg);
    assign r_period     = est_reg[OUT_PER_BITS-1:0];

    a_resync_acc: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load && rs_reg |-> acc_reg)
        else $error("resync without accept");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !dv_busy_reg)
        else $error("multiply while dividing");
    a_period_range: assert property (@(posedge clk) disable iff (!rst_n)
        est_reg <= PMAX)
        else $error("period out of range");

endmodule

### hw/rtl/frame_timestamp_smoother_top.sv
// Frame timestamp smoother: one result beat per input beat. A tracking update runs a 64-step
// divide of the measured period, a 32-step frame advance multiply, two 17-step gain multiplies
// and control steps; a resyncing update runs only the divide and the multiply, a query one
// 32-step multiply, and initialise, stale or unused requests go straight to the output. One
// item is processed at a time; the result sits in an output register until taken. A new item
// can be accepted while it waits, but a stalled receiver then holds back the next result.
module frame_timestamp_smoother_top
    import fts_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int FRAME_BITS = 32,
    parameter int FRAC_BITS  = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [REQ_BITS-1:0]      req_type,
    input  logic [IN_FRAME_BITS-1:0] frame_count,
    input  logic [OUT_TIME_BITS-1:0] clock_time,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     accepted,
    output logic                     resynced,
    output logic [OUT_TIME_BITS-1:0] frame_time,
    output logic [OUT_PER_BITS-1:0]  period_estimate,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [31:0]              cfg_data
);

    logic [NOM_BITS-1:0]  nominal_period_reg;
    logic [31:0]          resync_window_reg, max_adjust_reg;
    logic [7:0]           max_frame_gap_reg;
    logic [GAIN_BITS-1:0] period_gain_reg, offset_gain_reg;
    fts_cmd_t    cmd;
    fts_status_t status;
    logic r_acc, r_rs;
    logic [OUT_TIME_BITS-1:0] r_ft;
    logic [OUT_PER_BITS-1:0]  r_per;
    logic out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nominal_period_reg <= NOM_BITS'(10000000);
            resync_window_reg  <= 32'd200000000;
            max_adjust_reg     <= 32'd1000000;
            max_frame_gap_reg  <= 8'd10;
            period_gain_reg    <= GAIN_BITS'(655);
            offset_gain_reg    <= GAIN_BITS'(6554);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NOMINAL_PERIOD: nominal_period_reg <= cfg_data[NOM_BITS-1:0];
                CFG_RESYNC_WINDOW:  resync_window_reg  <= cfg_data;
                CFG_MAX_ADJUST:     max_adjust_reg     <= cfg_data;
                CFG_MAX_FRAME_GAP:  max_frame_gap_reg  <= cfg_data[7:0];
                CFG_PERIOD_GAIN:    period_gain_reg    <= cfg_data[GAIN_BITS-1:0];
                CFG_OFFSET_GAIN:    offset_gain_reg    <= cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    fts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_slot_free(!out_valid_reg || out_ready), .status(status), .cmd(cmd)
    );

    fts_datapath #(.TIME_BITS(TIME_BITS), .FRAME_BITS(FRAME_BITS), .FRAC_BITS(FRAC_BITS))
    u_dp (
        .clk(clk), .rst_n(rst_n), .req_type(req_type), .frame_count(frame_count),
        .clock_time(clock_time), .nominal_period(nominal_period_reg),
        .resync_window(resync_window_reg), .max_adjust(max_adjust_reg),
        .max_frame_gap(max_frame_gap_reg), .period_gain(period_gain_reg),
        .offset_gain(offset_gain_reg), .cmd(cmd), .status(status),
        .r_accepted(r_acc), .r_resynced(r_rs), .r_frame_time(r_ft), .r_period(r_per)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            accepted        <= r_acc;
            resynced        <= r_rs;
            frame_time      <= r_ft;
            period_estimate <= r_per;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### test/tb_frame_timestamp_smoother_top.sv
`timescale 1ns / 1ps

module tb_frame_timestamp_smoother_top
    import fts_pkg::*;
;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;
    localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] PER_MAX = (64'd1 << 46) - 64'd1;
    localparam logic [63:0] GAIN_UNITY = 64'd65536;
    localparam logic [45:0] RST_PER = 46'd655360000000;
    localparam int N_DIR = 13;

    typedef struct packed {
        logic        accepted;
        logic        resynced;
        logic [47:0] frame_time;
        logic [45:0] period;
    } smooth_res_t;

    typedef struct packed {
        logic [1:0]  req;
        logic [31:0] frame;
        logic [47:0] ctime;
        logic        typed;
        smooth_res_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [REQ_BITS-1:0] req_type;
    logic [IN_FRAME_BITS-1:0] frame_count;
    logic [OUT_TIME_BITS-1:0] clock_time;
    logic out_valid;
    logic out_ready;
    logic accepted;
    logic resynced;
    logic [OUT_TIME_BITS-1:0] frame_time;
    logic [OUT_PER_BITS-1:0] period_estimate;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [31:0] cfg_data;

    frame_timestamp_smoother_top dut (.*);

    // predictor copy of registers and state
    logic [29:0] pv_nominal;
    logic [31:0] pv_window;
    logic [31:0] pv_adjust;
    logic [7:0]  pv_gap;
    logic [16:0] pv_pgain;
    logic [16:0] pv_ogain;
    logic [63:0] pv_pred;
    logic [63:0] pv_newest;
    logic [63:0] pv_est;
    logic [63:0] pv_next;

    smooth_res_t result_q[$];
    int errors = 0;
    int snd_idle = 0;
    int rcv_idle = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("frame_timestamp_smoother_top test failed");
        $finish;
    end

    function automatic logic [63:0] sat_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = a * b;
        return (p[127:64] != 0) ? '1 : p[63:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [63:0] gain_scale(input logic [63:0] mag, input logic [16:0] gain);
        logic [63:0] g;
        g = ({47'd0, gain} > GAIN_UNITY) ? GAIN_UNITY : {47'd0, gain};
        return (mag >> 16) * g + (((mag & 64'hFFFF) * g) >> 16);
    endfunction

    function automatic logic [63:0] period_add(input logic [63:0] base, input logic neg,
                                               input logic [63:0] mag);
        logic [63:0] s;
        if (neg)
            return (mag >= base) ? 64'd0 : base - mag;
        s = sat_add(base, mag);
        return (s > PER_MAX) ? PER_MAX : s;
    endfunction

    function automatic void smoother_init();
        pv_pred = 0;
        pv_newest = 0;
        pv_est = ({34'd0, pv_nominal} << 16) & PER_MAX;
        pv_next = pv_est;
    endfunction

    function automatic smooth_res_t smoother_step(input logic [1:0] rq, input logic [31:0] fr,
                                                  input logic [47:0] ct);
        logic [63:0] tq, gap, mmag, dmag, emag, lim, adj, prod, val, fr64;
        logic mneg, dneg, eneg;
        smooth_res_t r;
        r = '0;
        tq = {ct, 16'h0};
        fr64 = {32'd0, fr};
        if (rq == REQ_UPDATE && fr64 > pv_newest)
        begin
            gap = fr64 - pv_newest;
            mneg = tq < pv_pred;
            mmag = (mneg ? pv_pred - tq : tq - pv_pred) / gap;
            if (mneg)
            begin
                dneg = 1'b1;
                dmag = sat_add(mmag, pv_est);
            end
            else if (mmag >= pv_est)
            begin
                dneg = 1'b0;
                dmag = mmag - pv_est;
            end
            else
            begin
                dneg = 1'b1;
                dmag = pv_est - mmag;
            end
            // q time range is the full 64 bits here, so saturation is the only clamp
            pv_pred = sat_add(pv_pred, sat_mul(gap, pv_next));
            pv_newest = fr64;
            eneg = tq < pv_pred;
            emag = eneg ? pv_pred - tq : tq - pv_pred;
            r.accepted = 1'b1;
            if (emag > ({32'd0, pv_window} << 16) || gap > {56'd0, pv_gap})
            begin
                pv_next = pv_est;
                pv_pred = tq;
                r.resynced = 1'b1;
            end
            else
            begin
                lim = {32'd0, pv_adjust} << 16;
                pv_est = period_add(pv_est, dneg, gain_scale(dmag, pv_pgain));
                adj = gain_scale(emag, pv_ogain);
                if (adj > lim)
                    adj = lim;
                pv_next = period_add(pv_est, eneg, adj);
            end
        end
        else if (rq == REQ_QUERY)
        begin
            if (fr64 <= pv_newest)
            begin
                prod = sat_mul(pv_est, pv_newest - fr64);
                val = (prod >= pv_pred) ? 64'd0 : pv_pred - prod;
            end
            else
                val = sat_add(pv_pred, sat_mul(pv_est, fr64 - pv_newest));
            val = val >> 16;
            r.frame_time = (val > TIME_MAX) ? TIME_MAX[47:0] : val[47:0];
        end
        else if (rq == REQ_INIT)
            smoother_init();
        r.period = pv_est[45:0];
        return r;
    endfunction

    task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
        $display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    // result side: compare at the edge, then pick the next ready level
    always @(posedge clk)
    begin
        smooth_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
                report("unexpected beat", 0, 1);
            else
            begin
                e = result_q.pop_front();
                if (accepted !== e.accepted)
                    report("accepted", e.accepted, accepted);
                if (resynced !== e.resynced)
                    report("resynced", e.resynced, resynced);
                if (frame_time !== e.frame_time)
                    report("frame_time", e.frame_time, frame_time);
                if (period_estimate !== e.period)
                    report("period_estimate", e.period, period_estimate);
            end
        end
        out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    task automatic send(input logic [1:0] rq, input logic [31:0] fr, input logic [47:0] ct,
                        input logic typed, input smooth_res_t want);
        smooth_res_t p;
        while ($urandom_range(99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rq;
        frame_count <= fr;
        clock_time <= ct;
        do
            @(posedge clk);
        while (!in_ready);
        p = smoother_step(rq, fr, ct);
        result_q.push_back(typed ? want : p);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_NOMINAL_PERIOD: pv_nominal = val[29:0];
            CFG_RESYNC_WINDOW:  pv_window = val;
            CFG_MAX_ADJUST:     pv_adjust = val;
            CFG_MAX_FRAME_GAP:  pv_gap = val[7:0];
            CFG_PERIOD_GAIN:    pv_pgain = val[16:0];
            CFG_OFFSET_GAIN:    pv_ogain = val[16:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (result_q.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic setup(input int set);
        logic [31:0] v[6];
        case (set)
            0: v = '{32'd10000000, 32'd200000000, 32'd1000000, 32'd10, 32'd655, 32'd6554};
            1: v = '{32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0};
            2: v = '{32'd1000000000, '1, '1, 32'd255, 32'd65536, 32'd65536};
            // zero nominal and gains above one
            3: v = '{32'd0, 32'd50000, 32'd3000, 32'd40, 32'h1FFFF, 32'h1FFFF};
            4: v = '{$urandom_range(20000000, 1000), $urandom_range(400000000),
                     $urandom_range(5000000), $urandom_range(30, 1),
                     $urandom_range(65536), $urandom_range(65536)};
            default: v = '{$urandom & 32'h3FFF_FFFF, $urandom, $urandom, $urandom & 32'hFF,
                           $urandom & 32'h1FFFF, $urandom & 32'h1FFFF};
        endcase
        cfg_write(CFG_NOMINAL_PERIOD, v[0]);
        cfg_write(CFG_RESYNC_WINDOW, v[1]);
        cfg_write(CFG_MAX_ADJUST, v[2]);
        cfg_write(CFG_MAX_FRAME_GAP, v[3]);
        cfg_write(CFG_PERIOD_GAIN, v[4]);
        cfg_write(CFG_OFFSET_GAIN, v[5]);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_item();
        int pick;
        logic [63:0] gap, t, jit;
        logic [31:0] fr;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(300, 1) : $urandom_range(3, 1);
            fr = pv_newest[31:0] + gap[31:0];
            jit = {34'd0, pv_nominal} >> $urandom_range(8, 2);
            t = pv_pred[63:16] + gap * pv_nominal;
            if ($urandom_range(1))
                t = t + (jit == 0 ? 0 : $urandom % jit);
            else
                t = t - (jit == 0 ? 0 : $urandom % jit);
            if ($urandom_range(19) == 0)
                t = {$urandom, $urandom};
            send(REQ_UPDATE, fr, t[47:0], 1'b0, '0);
        end
        else if (pick < 85)
        begin
            fr = ($urandom_range(9) == 0) ? $urandom
                 : pv_newest[31:0] + $urandom_range(40) - 20;
            send(REQ_QUERY, fr, {$urandom, $urandom}, 1'b0, '0);
        end
        else if (pick < 89)
            send(REQ_INIT, $urandom, {$urandom, $urandom}, 1'b0, '0);
        else if (pick < 94)
            send(REQ_UPDATE, pv_newest[31:0] - $urandom_range(3), {$urandom, $urandom},
                 1'b0, '0);
        else
            send(2'($urandom_range(3)), $urandom, {$urandom, $urandom}, 1'b0, '0);
    endtask

    initial
    begin
        dir_row_t rows[N_DIR];
        rows = '{
            '{REQ_QUERY,  32'd0, 48'd0, 1'b1, '{1'b0, 1'b0, 48'd0, RST_PER}},
            '{REQ_UPDATE, 32'd0, 48'd5, 1'b1, '{1'b0, 1'b0, 48'd0, RST_PER}},
            '{REQ_UNUSED, '1, '1, 1'b1, '{1'b0, 1'b0, 48'd0, RST_PER}},
            '{REQ_UPDATE, 32'd1, 48'd10000000, 1'b1, '{1'b1, 1'b0, 48'd0, RST_PER}},
            '{REQ_UPDATE, 32'd2, 48'd20000000, 1'b1, '{1'b1, 1'b0, 48'd0, RST_PER}},
            '{REQ_UPDATE, 32'd100, 48'd1000000000, 1'b1, '{1'b1, 1'b1, 48'd0, RST_PER}},
            '{REQ_QUERY,  32'd0, 48'd0, 1'b1, '{1'b0, 1'b0, 48'd0, RST_PER}},
            '{REQ_QUERY,  '1, 48'd0, 1'b1, '{1'b0, 1'b0, '1, RST_PER}},
            '{REQ_UPDATE, 32'd101, '1, 1'b0, '0},
            '{REQ_UPDATE, 32'd102, 48'd0, 1'b0, '0},
            '{REQ_QUERY,  32'd50, 48'd0, 1'b0, '0},
            '{REQ_INIT,   32'd7, 48'd7, 1'b1, '{1'b0, 1'b0, 48'd0, RST_PER}},
            '{REQ_UPDATE, '1, 48'd123456789, 1'b0, '0}
        };
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = REQ_UPDATE;
        frame_count = '0;
        clock_time = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_NOMINAL_PERIOD;
        cfg_data = '0;
        pv_nominal = 30'd10000000;
        pv_window = 32'd200000000;
        pv_adjust = 32'd1000000;
        pv_gap = 8'd10;
        pv_pgain = 17'd655;
        pv_ogain = 17'd6554;
        smoother_init();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send(rows[i].req, rows[i].frame, rows[i].ctime, rows[i].typed, rows[i].res);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            snd_idle = (ph < 2) ? 30 : (ph < 4) ? 88 : 0;
            rcv_idle = (ph < 2) ? 88 : (ph < 4) ? 30 : 0;
            setup(ph);
            send(REQ_INIT, 32'd0, 48'd0, 1'b0, '0);
            for (int n = 0; n < 215; n++)
                random_item();
            drain();
        end

        if (errors == 0)
            $display("frame_timestamp_smoother_top test passed");
        else
            $display("frame_timestamp_smoother_top test failed");
        $finish;
    end

endmodule

### files.f
hw/rtl/fts_pkg.sv
hw/rtl/fts_ctrl.sv
hw/rtl/fts_datapath.sv
hw/rtl/frame_timestamp_smoother_top.sv
test/tb_frame_timestamp_smoother_top.sv
